### rtl/lks_pkg.sv
// Shared types, widths and helpers for the LRU key store.
// Used by lks_ctrl and lru_key_store; no dependencies.
package lks_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W  = IDX_W;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam int OP_W   = 2;
    localparam int ADDR_W = 48;
    localparam int KEY_W  = 64;
    localparam int KIND_W = 8;
    localparam int POS_W  = 4;

    localparam int CMP_W  = (POS_W > CNT_W) ? POS_W : CNT_W;
    localparam int TAG_W  = ADDR_W + RANK_W;
    localparam int KREC_W = 2 * KEY_W + KIND_W;

    localparam logic [IDX_W:0]   IDX_END  = (IDX_W + 1)'(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 2'd0,
        OP_STORE  = 2'd1,
        OP_DELETE = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [RANK_W-1:0] rank;
    } t_tag;

    typedef struct packed {
        logic [KEY_W-1:0]  key_upper;
        logic [KEY_W-1:0]  key_lower;
        logic [KIND_W-1:0] kind;
    } t_krec;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } t_ram_ctl;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] address;
        logic [KEY_W-1:0]  key_upper;
        logic [KEY_W-1:0]  key_lower;
        logic [KIND_W-1:0] kind;
    } t_result;

    function automatic logic [CMP_W-1:0] ext_rank(input logic [RANK_W-1:0] v);
        return CMP_W'(v);
    endfunction

    function automatic logic [CMP_W-1:0] ext_pos(input logic [POS_W-1:0] v);
        return CMP_W'(v);
    endfunction

    function automatic logic [CMP_W-1:0] ext_cnt(input logic [CNT_W-1:0] v);
        return CMP_W'(v);
    endfunction

endpackage

### rtl/lru_key_store.sv
// LRU key store top level: sequencer, tag RAM, key RAM and output register.
// Depends on lks_pkg, lks_ram and lks_ctrl.
//
// Input channel: i_valid with o_stall; a transaction carries an operation
// (lookup, store, delete, read by recency rank), a 48-bit device address,
// a 128-bit key split into two halves, a type code and a rank.
// Output channel: o_valid with i_stall; one result transaction per input
// transaction, in order: o_found plus the returned entry, zero when none.
// One transaction is processed at a time; o_stall is high while it runs.
// Every operation walks the tag RAM once through its
// single read port, then passes a decide state. Operations that change the
// recency order walk it a second time to rewrite the ranks.
// Reading a key adds a fetch and a load on the key RAM.
// The next transaction is accepted once the result has gone to the output register.
// A result held by i_stall waits in the output register while the
// next transaction is accepted; that one then waits for the register.
// Reset clears the valid marks and the fill count at once; entry data is
// left as is and never used before it is written.
module lru_key_store (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [lks_pkg::OP_W-1:0]     i_operation,
    input  logic [lks_pkg::ADDR_W-1:0]   i_device_address,
    input  logic [lks_pkg::KEY_W-1:0]    i_key_upper,
    input  logic [lks_pkg::KEY_W-1:0]    i_key_lower,
    input  logic [lks_pkg::KIND_W-1:0]   i_key_kind,
    input  logic [lks_pkg::POS_W-1:0]    i_recency_position,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_found,
    output logic [lks_pkg::ADDR_W-1:0]   o_out_address,
    output logic [lks_pkg::KEY_W-1:0]    o_out_key_upper,
    output logic [lks_pkg::KEY_W-1:0]    o_out_key_lower,
    output logic [lks_pkg::KIND_W-1:0]   o_out_kind
);

    lks_pkg::t_ram_ctl            tag_ctl;
    lks_pkg::t_tag                tag_wdata;
    lks_pkg::t_tag                tag_rdata;
    logic [lks_pkg::TAG_W-1:0]    tag_rdata_raw;
    lks_pkg::t_ram_ctl            key_ctl;
    lks_pkg::t_krec               key_wdata;
    lks_pkg::t_krec               key_rdata;
    logic [lks_pkg::KREC_W-1:0]   key_rdata_raw;
    logic                         res_valid;
    lks_pkg::t_result             res;
    logic                         out_free;

    logic                         r_out_vld;
    lks_pkg::t_result             r_out;

    lks_ctrl u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_operation        (i_operation),
        .i_device_address   (i_device_address),
        .i_key_upper        (i_key_upper),
        .i_key_lower        (i_key_lower),
        .i_key_kind         (i_key_kind),
        .i_recency_position (i_recency_position),
        .o_tag_ctl          (tag_ctl),
        .o_tag_wdata        (tag_wdata),
        .i_tag_rdata        (tag_rdata),
        .o_key_ctl          (key_ctl),
        .o_key_wdata        (key_wdata),
        .i_key_rdata        (key_rdata),
        .o_res_valid        (res_valid),
        .o_res              (res),
        .i_res_take         (out_free)
    );

    lks_ram #(
        .WIDTH (lks_pkg::TAG_W),
        .DEPTH (lks_pkg::ENTRIES)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_ctl.we),
        .i_waddr (tag_ctl.waddr),
        .i_wdata (tag_wdata),
        .i_re    (tag_ctl.re),
        .i_raddr (tag_ctl.raddr),
        .o_rdata (tag_rdata_raw)
    );

    lks_ram #(
        .WIDTH (lks_pkg::KREC_W),
        .DEPTH (lks_pkg::ENTRIES)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_ctl.we),
        .i_waddr (key_ctl.waddr),
        .i_wdata (key_wdata),
        .i_re    (key_ctl.re),
        .i_raddr (key_ctl.raddr),
        .o_rdata (key_rdata_raw)
    );

    assign tag_rdata = lks_pkg::t_tag'(tag_rdata_raw);
    assign key_rdata = lks_pkg::t_krec'(key_rdata_raw);

    assign out_free = !r_out_vld || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_found         = r_out.found;
    assign o_out_address   = r_out.address;
    assign o_out_key_upper = r_out.key_upper;
    assign o_out_key_lower = r_out.key_lower;
    assign o_out_kind      = r_out.kind;

endmodule

### rtl/lks_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module lks_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/lks_ctrl.sv
// Sequencer of the LRU key store: scan, decide, rank update and key fetch.
// Holds the valid bits and fill count; drives the tag and key RAMs. Uses lks_pkg.
module lks_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [lks_pkg::OP_W-1:0]     i_operation,
    input  logic [lks_pkg::ADDR_W-1:0]   i_device_address,
    input  logic [lks_pkg::KEY_W-1:0]    i_key_upper,
    input  logic [lks_pkg::KEY_W-1:0]    i_key_lower,
    input  logic [lks_pkg::KIND_W-1:0]   i_key_kind,
    input  logic [lks_pkg::POS_W-1:0]    i_recency_position,
    output lks_pkg::t_ram_ctl            o_tag_ctl,
    output lks_pkg::t_tag                o_tag_wdata,
    input  lks_pkg::t_tag                i_tag_rdata,
    output lks_pkg::t_ram_ctl            o_key_ctl,
    output lks_pkg::t_krec               o_key_wdata,
    input  lks_pkg::t_krec               i_key_rdata,
    output logic                         o_res_valid,
    output lks_pkg::t_result             o_res,
    input  logic                         i_res_take
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SCAN   = 7'b0000010,
        ST_DECIDE = 7'b0000100,
        ST_UPDATE = 7'b0001000,
        ST_FETCH  = 7'b0010000,
        ST_LOAD   = 7'b0100000,
        ST_RESULT = 7'b1000000
    } t_state;

    t_state                             r_state, n_state;
    logic [lks_pkg::ENTRIES-1:0]        r_valid, n_valid;
    logic [lks_pkg::CNT_W-1:0]          r_used, n_used;
    logic                               r_rd_pend, n_rd_pend;

    lks_pkg::t_op                       r_op, n_op;
    logic [lks_pkg::ADDR_W-1:0]         r_addr, n_addr;
    lks_pkg::t_krec                     r_krec, n_krec;
    logic [lks_pkg::POS_W-1:0]          r_pos, n_pos;
    logic [lks_pkg::IDX_W:0]            r_idx, n_idx;
    logic [lks_pkg::IDX_W-1:0]          r_rd_idx, n_rd_idx;
    logic                               r_hit, n_hit;
    logic [lks_pkg::IDX_W-1:0]          r_hit_idx, n_hit_idx;
    logic [lks_pkg::RANK_W-1:0]         r_hit_rank, n_hit_rank;
    logic                               r_free, n_free;
    logic [lks_pkg::IDX_W-1:0]          r_free_idx, n_free_idx;
    logic [lks_pkg::IDX_W-1:0]          r_lru_idx, n_lru_idx;
    logic                               r_rnk_hit, n_rnk_hit;
    logic [lks_pkg::IDX_W-1:0]          r_rnk_idx, n_rnk_idx;
    logic [lks_pkg::ADDR_W-1:0]         r_rnk_addr, n_rnk_addr;
    logic [lks_pkg::IDX_W-1:0]          r_tgt, n_tgt;
    logic [lks_pkg::CMP_W-1:0]          r_limit, n_limit;
    logic                               r_demote, n_demote;
    lks_pkg::t_result                   r_res, n_res;

    logic                               issue;
    logic                               last;
    logic                               slot_ok;
    logic [lks_pkg::CNT_W-1:0]          used_m1;

    assign issue   = (r_idx != lks_pkg::IDX_END);
    assign last    = r_rd_pend && (r_rd_idx == lks_pkg::LAST_IDX);
    assign slot_ok = r_rd_pend && r_valid[r_rd_idx];
    assign used_m1 = r_used - 1'b1;

    always_comb begin
        n_state    = r_state;
        n_valid    = r_valid;
        n_used     = r_used;
        n_rd_pend  = r_rd_pend;
        n_op       = r_op;
        n_addr     = r_addr;
        n_krec     = r_krec;
        n_pos      = r_pos;
        n_idx      = r_idx;
        n_rd_idx   = r_rd_idx;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_hit_rank = r_hit_rank;
        n_free     = r_free;
        n_free_idx = r_free_idx;
        n_lru_idx  = r_lru_idx;
        n_rnk_hit  = r_rnk_hit;
        n_rnk_idx  = r_rnk_idx;
        n_rnk_addr = r_rnk_addr;
        n_tgt      = r_tgt;
        n_limit    = r_limit;
        n_demote   = r_demote;
        n_res      = r_res;

        o_tag_ctl   = '0;
        o_tag_wdata = '0;
        o_key_ctl   = '0;
        o_key_wdata = r_krec;

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_op            = lks_pkg::t_op'(i_operation);
                    n_addr          = i_device_address;
                    n_krec.key_upper = i_key_upper;
                    n_krec.key_lower = i_key_lower;
                    n_krec.kind     = i_key_kind;
                    n_pos           = i_recency_position;
                    n_idx           = '0;
                    n_rd_pend       = 1'b0;
                    n_hit           = 1'b0;
                    n_free          = 1'b0;
                    n_rnk_hit       = 1'b0;
                    n_lru_idx       = '0;
                    n_state         = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_tag_ctl.re    = issue;
                o_tag_ctl.raddr = r_idx[lks_pkg::IDX_W-1:0];
                n_rd_pend       = issue;
                n_rd_idx        = r_idx[lks_pkg::IDX_W-1:0];
                if (issue) begin
                    n_idx = r_idx + 1'b1;
                end
                if (slot_ok && !r_hit && i_tag_rdata.address == r_addr) begin
                    n_hit      = 1'b1;
                    n_hit_idx  = r_rd_idx;
                    n_hit_rank = i_tag_rdata.rank;
                end
                if (r_rd_pend && !r_valid[r_rd_idx] && !r_free) begin
                    n_free     = 1'b1;
                    n_free_idx = r_rd_idx;
                end
                if (slot_ok && lks_pkg::ext_rank(i_tag_rdata.rank) ==
                        lks_pkg::ext_cnt(used_m1)) begin
                    n_lru_idx = r_rd_idx;
                end
                if (slot_ok && lks_pkg::ext_rank(i_tag_rdata.rank) ==
                        lks_pkg::ext_pos(r_pos)) begin
                    n_rnk_hit  = 1'b1;
                    n_rnk_idx  = r_rd_idx;
                    n_rnk_addr = i_tag_rdata.address;
                end
                if (last) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                n_rd_pend = 1'b0;
                n_idx     = '0;
                n_res     = '0;
                n_demote  = 1'b0;
                case (r_op)
                    lks_pkg::OP_LOOKUP: begin
                        if (r_hit) begin
                            n_tgt         = r_hit_idx;
                            n_limit       = lks_pkg::ext_rank(r_hit_rank);
                            n_res.address = r_addr;
                            n_state       = ST_UPDATE;
                        end else begin
                            n_state = ST_RESULT;
                        end
                    end
                    lks_pkg::OP_STORE: begin
                        if (r_hit) begin
                            n_tgt   = r_hit_idx;
                            n_limit = lks_pkg::ext_rank(r_hit_rank);
                        end else if (r_used != lks_pkg::FULL_CNT) begin
                            n_tgt   = r_free_idx;
                            n_limit = lks_pkg::ext_cnt(r_used);
                            n_used  = r_used + 1'b1;
                        end else begin
                            n_tgt   = r_lru_idx;
                            n_limit = lks_pkg::ext_cnt(used_m1);
                        end
                        n_valid[n_tgt]  = 1'b1;
                        o_key_ctl.we    = 1'b1;
                        o_key_ctl.waddr = n_tgt;
                        n_res.found     = 1'b1;
                        n_state         = ST_UPDATE;
                    end
                    lks_pkg::OP_DELETE: begin
                        if (r_hit) begin
                            n_valid[r_hit_idx] = 1'b0;
                            n_used             = used_m1;
                            n_tgt              = r_hit_idx;
                            n_limit            = lks_pkg::ext_rank(r_hit_rank);
                            n_demote           = 1'b1;
                            n_res.found        = 1'b1;
                            n_state            = ST_UPDATE;
                        end else begin
                            n_state = ST_RESULT;
                        end
                    end
                    lks_pkg::OP_READ: begin
                        if (r_rnk_hit &&
                                lks_pkg::ext_pos(r_pos) < lks_pkg::ext_cnt(r_used)) begin
                            n_tgt         = r_rnk_idx;
                            n_res.address = r_rnk_addr;
                            n_state       = ST_FETCH;
                        end else begin
                            n_state = ST_RESULT;
                        end
                    end
                    default: begin
                        n_state = ST_RESULT;
                    end
                endcase
            end
            ST_UPDATE: begin
                o_tag_ctl.re    = issue;
                o_tag_ctl.raddr = r_idx[lks_pkg::IDX_W-1:0];
                o_tag_ctl.waddr = r_rd_idx;
                n_rd_pend       = issue;
                n_rd_idx        = r_idx[lks_pkg::IDX_W-1:0];
                if (issue) begin
                    n_idx = r_idx + 1'b1;
                end
                o_tag_wdata = i_tag_rdata;
                if (r_rd_pend) begin
                    if (r_rd_idx == r_tgt) begin
                        if (!r_demote) begin
                            o_tag_ctl.we        = 1'b1;
                            o_tag_wdata.address = r_addr;
                            o_tag_wdata.rank    = '0;
                        end
                    end else if (r_valid[r_rd_idx]) begin
                        if (!r_demote &&
                                lks_pkg::ext_rank(i_tag_rdata.rank) < r_limit) begin
                            o_tag_ctl.we     = 1'b1;
                            o_tag_wdata.rank = i_tag_rdata.rank + 1'b1;
                        end else if (r_demote &&
                                lks_pkg::ext_rank(i_tag_rdata.rank) > r_limit) begin
                            o_tag_ctl.we     = 1'b1;
                            o_tag_wdata.rank = i_tag_rdata.rank - 1'b1;
                        end
                    end
                end
                if (last) begin
                    n_state = (r_op == lks_pkg::OP_LOOKUP) ? ST_FETCH : ST_RESULT;
                end
            end
            ST_FETCH: begin
                n_rd_pend       = 1'b0;
                o_key_ctl.re    = 1'b1;
                o_key_ctl.raddr = r_tgt;
                n_state         = ST_LOAD;
            end
            ST_LOAD: begin
                n_res.found     = 1'b1;
                n_res.key_upper = i_key_rdata.key_upper;
                n_res.key_lower = i_key_rdata.key_lower;
                n_res.kind      = i_key_rdata.kind;
                n_state         = ST_RESULT;
            end
            ST_RESULT: begin
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_valid   <= '0;
            r_used    <= '0;
            r_rd_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_used    <= n_used;
            r_rd_pend <= n_rd_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_addr     <= n_addr;
        r_krec     <= n_krec;
        r_pos      <= n_pos;
        r_idx      <= n_idx;
        r_rd_idx   <= n_rd_idx;
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        r_hit_rank <= n_hit_rank;
        r_free     <= n_free;
        r_free_idx <= n_free_idx;
        r_lru_idx  <= n_lru_idx;
        r_rnk_hit  <= n_rnk_hit;
        r_rnk_idx  <= n_rnk_idx;
        r_rnk_addr <= n_rnk_addr;
        r_tgt      <= n_tgt;
        r_limit    <= n_limit;
        r_demote   <= n_demote;
        r_res      <= n_res;
    end

    assign o_stall     = (r_state != ST_IDLE);
    assign o_res_valid = (r_state == ST_RESULT);
    assign o_res       = r_res;

endmodule

### test/lru_key_store_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for lru_key_store: directed and random lookups, stores,
// deletes and rank reads, with replies checked against a tracked recency table.
// Depends on lks_pkg and the lru_key_store RTL.
module lru_key_store_tb;

    class key_store_board;
        bit                         slot_used[lks_pkg::ENTRIES];
        logic [lks_pkg::ADDR_W-1:0] slot_addr[lks_pkg::ENTRIES];
        logic [lks_pkg::KEY_W-1:0]  slot_upper[lks_pkg::ENTRIES];
        logic [lks_pkg::KEY_W-1:0]  slot_lower[lks_pkg::ENTRIES];
        logic [lks_pkg::KIND_W-1:0] slot_kind[lks_pkg::ENTRIES];
        int                         slot_rank[lks_pkg::ENTRIES];
        int                         fill;
        lks_pkg::t_result           pending_replies[$];
        int unsigned                errors;
        int unsigned                replies;
        int unsigned                op_seen[4];
        int unsigned                hits;
        int unsigned                evictions;
        int unsigned                peak_fill;

        function int find_addr(logic [lks_pkg::ADDR_W-1:0] addr);
            for (int i = 0; i < lks_pkg::ENTRIES; i++)
                if (slot_used[i] && slot_addr[i] == addr) return i;
            return -1;
        endfunction

        function int find_rank(int rank);
            for (int i = 0; i < lks_pkg::ENTRIES; i++)
                if (slot_used[i] && slot_rank[i] == rank) return i;
            return -1;
        endfunction

        // Move slot s to the front; everything ranked below limit shifts back one.
        function void promote(int s, int limit);
            for (int i = 0; i < lks_pkg::ENTRIES; i++)
                if (slot_used[i] && i != s && slot_rank[i] < limit) slot_rank[i]++;
            slot_rank[s] = 0;
        endfunction

        function lks_pkg::t_result entry_of(int s);
            lks_pkg::t_result res;
            res.found     = 1'b1;
            res.address   = slot_addr[s];
            res.key_upper = slot_upper[s];
            res.key_lower = slot_lower[s];
            res.kind      = slot_kind[s];
            return res;
        endfunction

        function lks_pkg::t_result apply_operation(lks_pkg::t_op op,
                                                   logic [lks_pkg::ADDR_W-1:0] addr,
                                                   logic [lks_pkg::KEY_W-1:0] upper,
                                                   logic [lks_pkg::KEY_W-1:0] lower,
                                                   logic [lks_pkg::KIND_W-1:0] kind,
                                                   logic [lks_pkg::POS_W-1:0] pos);
            lks_pkg::t_result res;
            int               s;
            int               r;
            res = '0;
            s = find_addr(addr);
            case (op)
                lks_pkg::OP_LOOKUP: begin
                    if (s >= 0) begin
                        promote(s, slot_rank[s]);
                        res = entry_of(s);
                        hits++;
                    end
                end
                lks_pkg::OP_STORE: begin
                    if (s >= 0) begin
                        promote(s, slot_rank[s]);
                        hits++;
                    end else if (fill < lks_pkg::ENTRIES) begin
                        s = 0;
                        while (slot_used[s]) s++;
                        promote(s, fill);
                        slot_used[s] = 1'b1;
                        fill++;
                    end else begin
                        s = find_rank(fill - 1);
                        promote(s, fill - 1);
                        evictions++;
                    end
                    slot_addr[s]  = addr;
                    slot_upper[s] = upper;
                    slot_lower[s] = lower;
                    slot_kind[s]  = kind;
                    res.found     = 1'b1;
                end
                lks_pkg::OP_DELETE: begin
                    if (s >= 0) begin
                        r = slot_rank[s];
                        slot_used[s] = 1'b0;
                        for (int i = 0; i < lks_pkg::ENTRIES; i++)
                            if (slot_used[i] && slot_rank[i] > r) slot_rank[i]--;
                        fill--;
                        res.found = 1'b1;
                        hits++;
                    end
                end
                default: begin
                    if (int'(pos) < fill) begin
                        res = entry_of(find_rank(int'(pos)));
                        hits++;
                    end
                end
            endcase
            if (fill > peak_fill) peak_fill = fill;
            return res;
        endfunction

        function void note_request(lks_pkg::t_op op, logic [lks_pkg::ADDR_W-1:0] addr,
                                   logic [lks_pkg::KEY_W-1:0] upper,
                                   logic [lks_pkg::KEY_W-1:0] lower,
                                   logic [lks_pkg::KIND_W-1:0] kind,
                                   logic [lks_pkg::POS_W-1:0] pos);
            op_seen[op]++;
            pending_replies.push_back(apply_operation(op, addr, upper, lower, kind, pos));
        endfunction

        function void check_reply(lks_pkg::t_result got);
            lks_pkg::t_result want;
            replies++;
            if (pending_replies.size() == 0) begin
                errors++;
                $display("%0t: reply with no transaction pending: %p", $time, got);
                return;
            end
            want = pending_replies.pop_front();
            if (got.found !== want.found) begin
                errors++;
                $display("%0t: found expected %0b got %0b", $time, want.found, got.found);
            end
            if (got.address !== want.address) begin
                errors++;
                $display("%0t: address expected %h got %h", $time, want.address, got.address);
            end
            if (got.key_upper !== want.key_upper) begin
                errors++;
                $display("%0t: key_upper expected %h got %h", $time, want.key_upper,
                         got.key_upper);
            end
            if (got.key_lower !== want.key_lower) begin
                errors++;
                $display("%0t: key_lower expected %h got %h", $time, want.key_lower,
                         got.key_lower);
            end
            if (got.kind !== want.kind) begin
                errors++;
                $display("%0t: kind expected %h got %h", $time, want.kind, got.kind);
            end
        endfunction
    endclass

    localparam logic [lks_pkg::ADDR_W-1:0] ADDR_ONES = '1;
    localparam logic [lks_pkg::KEY_W-1:0]  KEY_ONES  = '1;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_stall;
    logic [lks_pkg::OP_W-1:0]   i_operation;
    logic [lks_pkg::ADDR_W-1:0] i_device_address;
    logic [lks_pkg::KEY_W-1:0]  i_key_upper;
    logic [lks_pkg::KEY_W-1:0]  i_key_lower;
    logic [lks_pkg::KIND_W-1:0] i_key_kind;
    logic [lks_pkg::POS_W-1:0]  i_recency_position;
    logic                       o_valid;
    logic                       i_stall;
    logic                       o_found;
    logic [lks_pkg::ADDR_W-1:0] o_out_address;
    logic [lks_pkg::KEY_W-1:0]  o_out_key_upper;
    logic [lks_pkg::KEY_W-1:0]  o_out_key_lower;
    logic [lks_pkg::KIND_W-1:0] o_out_kind;

    key_store_board board = new;
    bit             sender_burst;
    bit             pressure_done;
    int             hold_left;
    int             stall_left;
    int             calm_left;
    int             rx_pick;

    lru_key_store u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_operation        (i_operation),
        .i_device_address   (i_device_address),
        .i_key_upper        (i_key_upper),
        .i_key_lower        (i_key_lower),
        .i_key_kind         (i_key_kind),
        .i_recency_position (i_recency_position),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_found            (o_found),
        .o_out_address      (o_out_address),
        .o_out_key_upper    (o_out_key_upper),
        .o_out_key_lower    (o_out_key_lower),
        .o_out_kind         (o_out_kind)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic pause_sender();
        int gap;
        int pick;
        gap = 0;
        pick = $urandom_range(0, 99);
        if (!sender_burst) begin
            if (pick >= 92) gap = $urandom_range(8, 40);
            else if (pick >= 55) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_request(lks_pkg::t_op op, logic [lks_pkg::ADDR_W-1:0] addr,
                                logic [lks_pkg::KEY_W-1:0] upper,
                                logic [lks_pkg::KEY_W-1:0] lower,
                                logic [lks_pkg::KIND_W-1:0] kind,
                                logic [lks_pkg::POS_W-1:0] pos);
        i_valid            <= 1'b1;
        i_operation        <= op;
        i_device_address   <= addr;
        i_key_upper        <= upper;
        i_key_lower        <= lower;
        i_key_kind         <= kind;
        i_recency_position <= pos;
        do @(posedge i_clk); while (o_stall);
        board.note_request(op, addr, upper, lower, kind, pos);
        pause_sender();
    endtask

    function automatic logic [lks_pkg::KEY_W-1:0] random_key();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0) return '0;
        if (sel == 1) return KEY_ONES;
        return {32'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [lks_pkg::ADDR_W-1:0] random_addr();
        return {16'($urandom), 32'($urandom)};
    endfunction

    task automatic run_directed();
        send_request(lks_pkg::OP_LOOKUP, '0, '0, '0, '0, '0);
        send_request(lks_pkg::OP_READ, '0, '0, '0, '0, 4'd0);
        send_request(lks_pkg::OP_DELETE, ADDR_ONES, '0, '0, '0, 4'd15);
        send_request(lks_pkg::OP_STORE, '0, KEY_ONES, KEY_ONES, 8'hFF, 4'd0);
        send_request(lks_pkg::OP_STORE, ADDR_ONES, '0, '0, 8'h00, 4'd15);
        send_request(lks_pkg::OP_STORE, 48'hAAAA_AAAA_AAAA, {16{4'h5}}, {16{4'hA}}, 8'h5A,
                     4'd5);
        send_request(lks_pkg::OP_LOOKUP, '0, '0, '0, '0, 4'd10);
        send_request(lks_pkg::OP_READ, '0, '0, '0, '0, 4'd0);
        send_request(lks_pkg::OP_READ, '0, '0, '0, '0, 4'd1);
        send_request(lks_pkg::OP_READ, '0, '0, '0, '0, 4'd2);
        send_request(lks_pkg::OP_READ, '0, '0, '0, '0, 4'd3);
        send_request(lks_pkg::OP_READ, '0, '0, '0, '0, 4'd15);
        send_request(lks_pkg::OP_STORE, ADDR_ONES, {16{4'hC}}, {16{4'h3}}, 8'hA5, 4'd0);
        send_request(lks_pkg::OP_LOOKUP, ADDR_ONES, '0, '0, '0, 4'd0);
        send_request(lks_pkg::OP_DELETE, 48'hAAAA_AAAA_AAAA, '0, '0, '0, 4'd0);
        send_request(lks_pkg::OP_READ, '0, '0, '0, '0, 4'd1);
        send_request(lks_pkg::OP_LOOKUP, 48'hAAAA_AAAA_AAAA, '0, '0, '0, 4'd0);
        send_request(lks_pkg::OP_DELETE, '0, '0, '0, '0, 4'd0);
        send_request(lks_pkg::OP_DELETE, '0, '0, '0, '0, 4'd0);
        send_request(lks_pkg::OP_READ, '0, '0, '0, '0, 4'd0);
        send_request(lks_pkg::OP_DELETE, ADDR_ONES, '0, '0, '0, 4'd0);
        send_request(lks_pkg::OP_READ, '0, '0, '0, '0, 4'd0);
    endtask

    task automatic run_random();
        logic [lks_pkg::ADDR_W-1:0] pool[24];
        logic [lks_pkg::ADDR_W-1:0] addr;
        int                         pool_size;
        int                         store_pct;
        int                         pick;
        lks_pkg::t_op               op;
        for (int phase = 0; phase < 17; phase++) begin
            pool_size    = (phase == 0) ? 24 : $urandom_range(2, 24);
            store_pct    = (phase == 0) ? 75 : $urandom_range(25, 70);
            sender_burst = ($urandom_range(0, 3) == 0);
            foreach (pool[i]) pool[i] = random_addr();
            for (int n = 0; n < 100; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < store_pct) op = lks_pkg::OP_STORE;
                else begin
                    pick = $urandom_range(0, 9);
                    op = (pick < 4) ? lks_pkg::OP_LOOKUP :
                         (pick < 7) ? lks_pkg::OP_READ : lks_pkg::OP_DELETE;
                end
                addr = ($urandom_range(0, 9) == 0) ? random_addr()
                                                   : pool[$urandom_range(0, pool_size - 1)];
                send_request(op, addr, random_key(), random_key(), 8'($urandom),
                             4'($urandom));
            end
        end
    endtask

    // Receiver: check replies, stall at random, and hold off once for a long stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall)
                board.check_reply({o_found, o_out_address, o_out_key_upper, o_out_key_lower,
                                   o_out_kind});
            if (!pressure_done && board.replies >= 500) begin
                pressure_done = 1'b1;
                hold_left = 600;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (calm_left > 0) begin
                calm_left--;
                i_stall <= 1'b0;
            end else begin
                rx_pick = $urandom_range(0, 99);
                if (rx_pick < 3) calm_left = $urandom_range(40, 300);
                else if (rx_pick < 8) stall_left = $urandom_range(8, 40);
                else if (rx_pick < 30) stall_left = $urandom_range(0, 2);
                i_stall <= (rx_pick >= 3 && rx_pick < 30);
            end
        end
    end

    initial begin
        i_rst_n            <= 1'b0;
        i_valid            <= 1'b0;
        i_operation        <= lks_pkg::OP_LOOKUP;
        i_device_address   <= '0;
        i_key_upper        <= '0;
        i_key_lower        <= '0;
        i_key_kind         <= '0;
        i_recency_position <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_random();
        i_valid <= 1'b0;
        while (board.pending_replies.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("Covered %0d transactions: %0d lookups, %0d stores, %0d deletes, %0d rank reads",
                 board.replies, board.op_seen[lks_pkg::OP_LOOKUP],
                 board.op_seen[lks_pkg::OP_STORE], board.op_seen[lks_pkg::OP_DELETE],
                 board.op_seen[lks_pkg::OP_READ]);
        $display("%0d hits, %0d evictions, table fill peaked at %0d of %0d",
                 board.hits, board.evictions, board.peak_fill, lks_pkg::ENTRIES);
        if (board.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
